>>> src/b64d_pkg.sv
// Package for the base64 stream decoder: shared types, constants and the
// character-to-value mapping. Used by the front, queue, back and top modules.
`default_nettype none

package b64d_pkg;

    localparam int unsigned COUNT_OUT_W = 16;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] PAD_VAL = 8'h7F;
    localparam logic [7:0] BAD_VAL = 8'hFF;
    localparam logic [7:0] PLUS_VAL  = 8'h3E;
    localparam logic [7:0] SLASH_VAL = 8'h3F;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ILLEGAL    = 2'd1,
        ST_INCOMPLETE = 2'd2,
        ST_SHORT      = 2'd3
    } b64d_status_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_COMMITTED = 2'd1,
        ERR_PENDING   = 2'd2
    } b64d_err_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } b64d_kind_t;

    // One queue entry holds every result caused by one input transaction.
    typedef struct packed {
        logic [2:0][7:0]        data;
        logic [1:0]             nbytes;
        logic                   has_status;
        b64d_status_t           status;
        logic [COUNT_OUT_W-1:0] count;
    } b64d_entry_t;

    // Maps one character through the standard alphabet; pad and illegal
    // characters get their own codes.
    function automatic logic [7:0] map_char(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c >= 8'h41 && c <= 8'h5A) begin
                v = c - 8'd65;
            end else if (c >= 8'h61 && c <= 8'h7A) begin
                v = c - 8'd71;
            end else if (c >= 8'h30 && c <= 8'h39) begin
                v = c + 8'd4;
            end else if (c == 8'h2B) begin
                v = PLUS_VAL;
            end else if (c == 8'h2F) begin
                v = SLASH_VAL;
            end else if (c == 8'h3D) begin
                v = PAD_VAL;
            end else begin
                v = BAD_VAL;
            end
            return v;
        end
    endfunction

endpackage

`default_nettype wire

>>> src/b64d_front.sv
// Front part of the base64 stream decoder: accepts characters, tracks group and
// error state, and queues one entry per transaction with results. Uses b64d_pkg.
`default_nettype none

module b64d_front
    import b64d_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  character,
    input  wire logic        end_of_text,
    input  wire logic        q_full,
    output logic             push,
    output b64d_entry_t      entry
);

    logic [1:0][6:0]        vals_reg, vals_next;
    logic [1:0]             pos_reg, pos_next;
    logic                   done_reg, done_next;
    b64d_err_t              err_reg, err_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [6:0]             val2_reg, val2_next;

    logic                   accept;
    logic [7:0]             v;
    logic                   ill;
    logic                   bad;
    logic [6:0]             a, b, c;
    logic [1:0]             nb;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] cnt_upd;
    logic [31:0]            cnt_ext;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign v        = map_char(character);
    assign ill      = (v == BAD_VAL);
    assign a        = vals_reg[0];
    assign b        = vals_reg[1];
    assign c        = val2_reg;
    assign bad      = (err_reg == ERR_PENDING) || ill || ({1'b0, a} == PAD_VAL) ||
                      ({1'b0, b} == PAD_VAL) || (({1'b0, c} == PAD_VAL) && (v != PAD_VAL));

    always_comb begin
        vals_next = vals_reg;
        val2_next = val2_reg;
        pos_next  = pos_reg;
        done_next = done_reg;
        err_next  = err_reg;
        nb        = 2'd0;
        entry     = '0;
        entry.data[0] = {a[5:0], b[5:4]};
        entry.data[1] = {b[3:0], c[5:2]};
        entry.data[2] = {c[1:0], v[5:0]};

        if (pos_reg != 2'd3) begin
            if (ill && err_reg == ERR_NONE) begin
                err_next = ERR_PENDING;
            end
            if (pos_reg == 2'd2) begin
                val2_next = ill ? 7'd0 : v[6:0];
            end else begin
                vals_next[pos_reg[0]] = ill ? 7'd0 : v[6:0];
            end
            pos_next = pos_reg + 2'd1;
        end else begin
            done_next = 1'b1;
            pos_next  = 2'd0;
            if (err_reg == ERR_NONE) begin
                if (bad) begin
                    err_next = ERR_COMMITTED;
                end else begin
                    nb = 2'd1 + 2'({1'b0, c} != PAD_VAL) + 2'(v != PAD_VAL);
                end
            end else if (err_reg == ERR_PENDING) begin
                err_next = ERR_COMMITTED;
            end
        end

        // Saturating byte count including the bytes of this group.
        sum = {1'b0, cnt_reg} + (COUNT_WIDTH+1)'(nb);
        if (sum > {1'b0, CNT_MAX}) begin
            cnt_upd = CNT_MAX;
        end else begin
            cnt_upd = sum[COUNT_WIDTH-1:0];
        end
        cnt_next = cnt_upd;
        cnt_ext  = 32'(cnt_upd);

        entry.nbytes     = nb;
        entry.has_status = end_of_text;
        entry.count      = end_of_text ? cnt_ext[COUNT_OUT_W-1:0] : '0;
        if (!done_next) begin
            entry.status = ST_SHORT;
        end else if (err_next == ERR_COMMITTED) begin
            entry.status = ST_ILLEGAL;
        end else if (pos_next != 2'd0) begin
            entry.status = ST_INCOMPLETE;
        end else begin
            entry.status = ST_OK;
        end

        if (end_of_text) begin
            pos_next  = 2'd0;
            done_next = 1'b0;
            err_next  = ERR_NONE;
            cnt_next  = '0;
        end

        push = accept && (end_of_text || nb != 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 2'd0;
            done_reg <= 1'b0;
            err_reg  <= ERR_NONE;
            cnt_reg  <= '0;
        end else if (accept) begin
            pos_reg  <= pos_next;
            done_reg <= done_next;
            err_reg  <= err_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            vals_reg <= vals_next;
            val2_reg <= val2_next;
        end
    end

endmodule

`default_nettype wire

>>> src/b64d_queue.sv
// Short first-in first-out queue of result entries between the front and back
// parts of the base64 stream decoder. Uses b64d_pkg.
`default_nettype none

module b64d_queue
    import b64d_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire b64d_entry_t  push_entry,
    input  wire logic         pop,
    output logic              full,
    output logic              empty,
    output b64d_entry_t       head
);

    b64d_entry_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_reg, rd_reg;
    logic [QPTR_W:0]         cnt_reg, cnt_next;

    assign full  = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> src/b64d_back.sv
// Back part of the base64 stream decoder: walks the results of the head queue
// entry one at a time into the output register. Uses b64d_pkg.
`default_nettype none

module b64d_back
    import b64d_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_empty,
    input  wire b64d_entry_t       head,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_kind,
    output logic [7:0]             m_data_byte,
    output logic [1:0]             m_status,
    output logic [COUNT_OUT_W-1:0] m_decoded_count,
    output logic                   m_last_result
);

    logic [1:0]             idx_reg;
    logic                   valid_reg;
    logic                   kind_reg;
    logic [7:0]             data_reg;
    logic [1:0]             status_reg;
    logic [COUNT_OUT_W-1:0] count_reg;
    logic                   last_reg;

    logic                   load;
    logic [2:0]             total;
    logic                   is_last;
    logic                   is_status;

    assign load      = !q_empty && (!valid_reg || m_ready);
    assign total     = {1'b0, head.nbytes} + {2'b00, head.has_status};
    assign is_last   = ({1'b0, idx_reg} == total - 3'd1);
    assign is_status = (idx_reg == head.nbytes);
    assign pop       = load && is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= is_last ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            last_reg <= is_last;
            if (is_status) begin
                kind_reg   <= KIND_STATUS;
                data_reg   <= 8'd0;
                status_reg <= head.status;
                count_reg  <= head.count;
            end else begin
                kind_reg   <= KIND_DATA;
                data_reg   <= head.data[idx_reg];
                status_reg <= ST_OK;
                count_reg  <= '0;
            end
        end
    end

    assign m_valid         = valid_reg;
    assign m_kind          = kind_reg;
    assign m_data_byte     = data_reg;
    assign m_status        = status_reg;
    assign m_decoded_count = count_reg;
    assign m_last_result   = last_reg;

endmodule

`default_nettype wire

>>> src/base64_stream_decoder_unit.sv
// Top level of the base64 stream decoder: front, result queue and back part.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
`default_nettype none

// The decoder takes one base64 character per input transaction, at up to one
// transaction per clock cycle, and keeps no limit on string length. Every
// fourth character closes a group that yields one to three data results; a
// character with s_end_of_text set also yields a status result (ok, illegal
// character, incomplete final group, or fewer than four characters) carrying
// the saturating count of bytes decoded for that string, after which the
// string state is cleared. The front part classifies each character in the
// cycle it is accepted and writes all results it causes into a four-entry
// queue; the back part drains that queue at one result transaction per cycle
// while m_ready is high, through a registered output. Input transactions
// that cause no result never occupy the queue, so the input side runs at one
// character per cycle as long as the output keeps pace with the result rate,
// at most four results for one character (a group end with end of text). A
// result passes queue memory, then output register. s_ready drops only when the
// queue is full. The internal counter is COUNT_WIDTH bits wide (8 to 32); its
// low 16 bits, zero extended when narrower, appear on m_decoded_count.

module base64_stream_decoder_unit
    import b64d_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_character,
    input  wire logic        s_end_of_text,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic [7:0]       m_data_byte,
    output logic [1:0]       m_status,
    output logic [15:0]      m_decoded_count,
    output logic             m_last_result
);

    // Queue handshake between the two halves.
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    b64d_entry_t push_entry;
    b64d_entry_t head;

    // The front part owns all per-string state, so a stalled output never
    // changes how characters are classified.
    b64d_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .character   (s_character),
        .end_of_text (s_end_of_text),
        .q_full      (q_full),
        .push        (push),
        .entry       (push_entry)
    );

    b64d_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (head)
    );

    // The back part turns each entry into its data and status transactions,
    // marking the final one of each entry with m_last_result.
    b64d_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .head            (head),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_data_byte     (m_data_byte),
        .m_status        (m_status),
        .m_decoded_count (m_decoded_count),
        .m_last_result   (m_last_result)
    );

endmodule

`default_nettype wire

>>> sim/tb_base64_stream_decoder_unit.sv
// Testbench for base64_stream_decoder_unit: a predictor that decodes each
// accepted character, a scoreboard for the result channel, and random idling.
// Depends on b64d_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module tb_base64_stream_decoder_unit;

    import b64d_pkg::*;

    localparam int unsigned CNT_W        = 16;
    localparam logic [31:0] CNT_MAX      = (CNT_W >= 32) ? 32'hFFFF_FFFF
                                                         : ((32'd1 << CNT_W) - 32'd1);
    localparam logic [6:0]  PAD7         = PAD_VAL[6:0];
    // Random characters after the directed part.
    localparam int unsigned RANDOM_CHARS = 360;
    // Cycles to watch for stray results once everything has arrived.
    localparam int unsigned TAIL_CYCLES  = 16;
    // Watchdog limit for the whole run, set with a wide margin.
    localparam int unsigned RUN_LIMIT    = 1_000_000;
    // Mismatch lines printed before the rest are only counted.
    localparam int unsigned MAX_REPORTS  = 20;

    // One character waiting to be sent. A hold makes the sender wait until
    // every expected result has arrived.
    typedef struct {
        logic [7:0] ch;
        logic       eot;
        logic       hold;
    } text_char_t;

    typedef struct {
        b64d_kind_t  kind;
        logic [7:0]  data;
        logic [1:0]  status;
        logic [15:0] count;
        logic        last;
    } dec_result_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_character   = 8'h00;
    logic        s_end_of_text = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic        m_kind;
    logic [7:0]  m_data_byte;
    logic [1:0]  m_status;
    logic [15:0] m_decoded_count;
    logic        m_last_result;

    string b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    text_char_t  pending_chars[$];
    dec_result_t decoded_results[$];
    dec_result_t want;

    // Predictor copy of the per-string decoder state.
    logic [6:0]  grp_val [3];
    logic [1:0]  grp_pos   = 2'd0;
    logic        grp_done  = 1'b0;
    b64d_err_t   grp_err   = ERR_NONE;
    logic [31:0] byte_cnt  = 32'd0;

    int unsigned chars_sent     = 0;
    int unsigned chars_accepted = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;
    int unsigned status_hist [4];
    int unsigned send_gap       = 0;
    int unsigned src_calm       = 0;
    int unsigned stall_left     = 0;
    int unsigned sink_calm      = 0;

    base64_stream_decoder_unit #(
        .COUNT_WIDTH(CNT_W)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_character    (s_character),
        .s_end_of_text  (s_end_of_text),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_data_byte    (m_data_byte),
        .m_status       (m_status),
        .m_decoded_count(m_decoded_count),
        .m_last_result  (m_last_result)
    );

    always #5 aclk = ~aclk;

    // Idle length: mostly none or short, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Six-bit value of an alphabet character, the pad code for '=', and the
    // illegal code for everything else.
    function automatic logic [7:0] sextet_of(input logic [7:0] ch);
        logic [7:0] v;
        v = BAD_VAL;
        for (int i = 0; i < 64; i++) begin
            if (b64_alphabet[i] == ch) v = 8'(i);
        end
        if (ch == "=") v = PAD_VAL;
        return v;
    endfunction

    // Builds a data result and counts the byte, saturating.
    function automatic dec_result_t data_result(input logic [7:0] value);
        if (byte_cnt < CNT_MAX) byte_cnt = byte_cnt + 32'd1;
        return '{KIND_DATA, value, ST_OK, 16'd0, 1'b0};
    endfunction

    // Advances the predictor by one accepted character and queues every
    // result it causes, the last of them flagged.
    function automatic void predict_char(input logic [7:0] ch, input logic eot);
        logic [7:0]  v;
        logic        ill;
        logic        bad;
        logic [6:0]  a;
        logic [6:0]  b;
        logic [6:0]  c;
        logic [6:0]  d;
        logic [1:0]  fin;
        dec_result_t batch[$];
        v   = sextet_of(ch);
        ill = (v == BAD_VAL);
        if (grp_pos < 2'd3) begin
            // An illegal character is only remembered here; it is judged
            // when its group closes.
            if (ill && grp_err == ERR_NONE) grp_err = ERR_PENDING;
            grp_val[grp_pos] = ill ? 7'd0 : v[6:0];
            grp_pos = grp_pos + 2'd1;
        end else begin
            a = grp_val[0];
            b = grp_val[1];
            c = grp_val[2];
            d = v[6:0];
            // A pad in the first two places, or a pad followed by a
            // non-pad, spoils the group like an illegal character.
            bad = (grp_err == ERR_PENDING) || ill || a == PAD7 || b == PAD7 ||
                  (c == PAD7 && d != PAD7);
            grp_done = 1'b1;
            grp_pos  = 2'd0;
            if (grp_err == ERR_NONE) begin
                if (bad) begin
                    grp_err = ERR_COMMITTED;
                end else begin
                    batch.push_back(data_result({a[5:0], b[5:4]}));
                    if (c != PAD7) batch.push_back(data_result({b[3:0], c[5:2]}));
                    if (d != PAD7) batch.push_back(data_result({c[1:0], d[5:0]}));
                end
            end else if (grp_err == ERR_PENDING) begin
                grp_err = ERR_COMMITTED;
            end
        end
        if (eot) begin
            if (!grp_done) fin = ST_SHORT;
            else if (grp_err == ERR_COMMITTED) fin = ST_ILLEGAL;
            else if (grp_pos != 2'd0) fin = ST_INCOMPLETE;
            else fin = ST_OK;
            batch.push_back('{KIND_STATUS, 8'h00, fin, byte_cnt[15:0], 1'b0});
            status_hist[fin]++;
            grp_pos  = 2'd0;
            grp_done = 1'b0;
            grp_err  = ERR_NONE;
            byte_cnt = 32'd0;
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) decoded_results.push_back(batch[i]);
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (exp_v !== got_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $error("Result %0d, %s: expected 0x%0h, got 0x%0h",
                       results_seen, name, exp_v, got_v);
            end
        end
    endtask

    task automatic queue_char(input logic [7:0] ch, input logic eot);
        pending_chars.push_back('{ch, eot, 1'b0});
    endtask

    task automatic queue_text(input string s, input logic eot_last);
        for (int i = 0; i < s.len(); i++) begin
            queue_char(s[i], eot_last && (i == s.len() - 1));
        end
    endtask

    // Sender. A character stays on the bus until the monitor has seen it
    // accepted; only then does the next gap or character begin.
    always @(negedge aclk) begin
        text_char_t next;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (chars_sent != chars_accepted) begin
            // Transaction still in flight: hold valid and payload.
        end else if (send_gap > 0) begin
            s_valid <= 1'b0;
            send_gap--;
        end else if (pending_chars.size() == 0) begin
            s_valid <= 1'b0;
        end else if (pending_chars[0].hold && decoded_results.size() != 0) begin
            // Pause until the block has delivered everything owed so far.
            s_valid <= 1'b0;
        end else begin
            next = pending_chars.pop_front();
            s_valid       <= 1'b1;
            s_character   <= next.ch;
            s_end_of_text <= next.eot;
            chars_sent++;
            if (src_calm > 0) begin
                src_calm--;
                send_gap = 0;
            end else if ($urandom_range(0, 39) == 0) begin
                src_calm = $urandom_range(15, 40);
                send_gap = 0;
            end else begin
                send_gap = idle_len();
            end
        end
    end

    // Receiver: random stalls on the result channel, with calm stretches.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (sink_calm > 0) begin
                sink_calm--;
            end else if ($urandom_range(0, 49) == 0) begin
                sink_calm = $urandom_range(30, 100);
            end else begin
                stall_left = idle_len();
            end
        end
    end

    // Monitor: every accepted character feeds the predictor, and every
    // accepted result is compared with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_char(s_character, s_end_of_text);
                chars_accepted++;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (decoded_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $error("Result %0d arrived with no result expected",
                               results_seen);
                    end
                end else begin
                    want = decoded_results.pop_front();
                    check_field("kind", 16'(want.kind), 16'(m_kind));
                    check_field("data_byte", 16'(want.data), 16'(m_data_byte));
                    check_field("status", 16'(want.status), 16'(m_status));
                    check_field("decoded_count", want.count, m_decoded_count);
                    check_field("last_result", 16'(want.last), 16'(m_last_result));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $error("Run stopped after %0d cycles with %0d results outstanding",
                   cycle_count, decoded_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int unsigned r;
        int unsigned groups;
        int unsigned len;
        int unsigned k;
        int unsigned first;
        int unsigned random_target;
        logic        first_random;
        logic [7:0]  txt[$];

        foreach (grp_val[i]) grp_val[i] = 7'd0;
        foreach (status_hist[i]) status_hist[i] = 0;

        // Directed strings. The first has a padded group in mid-string and
        // then the values 62, 63, digits, lowercase and all-zero groups; it
        // ends with a single pad.
        queue_text("QQ==", 1'b0);
        queue_text("+/9z", 1'b0);
        queue_text("AAAA", 1'b0);
        queue_text("//8=", 1'b1);
        // A pad in the second place spoils the group;
        // the string ends on a NUL byte and reports an illegal character.
        queue_text("Q=A=", 1'b0);
        queue_char(8'h00, 1'b1);
        // A good group, then a final partial group holding a high byte:
        // the string is reported incomplete.
        queue_text("AAAA", 1'b0);
        queue_char(8'h80, 1'b1);
        // A lone character: fewer than four.
        queue_char(8'hFF, 1'b1);

        // Random strings: mostly well formed with random content, padded
        // endings and partial tails, plus noise bytes, stray pads and some
        // plain garbage.
        random_target = pending_chars.size() + RANDOM_CHARS;
        first_random  = 1'b1;
        while (pending_chars.size() < random_target) begin
            txt.delete();
            r = $urandom_range(0, 99);
            if (r < 6) begin
                len = $urandom_range(1, 9);
                repeat (len) txt.push_back(8'($urandom_range(0, 255)));
            end else begin
                groups = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                repeat (groups * 4) txt.push_back(b64_alphabet[$urandom_range(0, 63)]);
                if (groups > 1 && $urandom_range(0, 7) == 0) begin
                    k = 4 * $urandom_range(0, groups - 2);
                    txt[k + 3] = "=";
                    if ($urandom_range(0, 1) == 1) txt[k + 2] = "=";
                end
                r = $urandom_range(0, 9);
                if (groups > 0 && r < 2) begin
                    txt[txt.size() - 1] = "=";
                end else if (groups > 0 && r < 4) begin
                    txt[txt.size() - 1] = "=";
                    txt[txt.size() - 2] = "=";
                end else if (r < 7 || groups == 0) begin
                    len = $urandom_range(1, 3);
                    repeat (len) txt.push_back(b64_alphabet[$urandom_range(0, 63)]);
                end
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
                end else if (r < 22) begin
                    txt[$urandom_range(0, txt.size() - 1)] = "=";
                end
            end
            first = pending_chars.size();
            foreach (txt[i]) queue_char(txt[i], i == txt.size() - 1);
            if (first_random || $urandom_range(0, 7) == 0) pending_chars[first].hold = 1'b1;
            first_random = 1'b0;
        end

        // Synchronous reset, released between edges.
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_chars.size() != 0 || chars_accepted != chars_sent) @(posedge aclk);
        while (decoded_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Decoded %0d characters into %0d result transactions over %0d strings.",
                 chars_accepted, results_seen,
                 status_hist[0] + status_hist[1] + status_hist[2] + status_hist[3]);
        $display("String endings ok/illegal/incomplete/short: %0d/%0d/%0d/%0d; %0d mismatches.",
                 status_hist[0], status_hist[1], status_hist[2], status_hist[3], mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
